// ===== rtl/dip_lip_bip_dead_block_replacement_macros.svh =====
// ----------------------------------------------------------------------------
// dead block replacement assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef DIP_LIP_BIP_DEAD_BLOCK_REPLACEMENT_MACROS_SVH
`define DIP_LIP_BIP_DEAD_BLOCK_REPLACEMENT_MACROS_SVH

// same-cycle implication
`define DLB_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dlb assertion failed");

// next-cycle implication
`define DLB_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dlb assertion failed");

`endif

// ===== rtl/dlb_pkg.sv =====
// ----------------------------------------------------------------------------
// dlb_pkg
// constants, row types and row functions of the dead block replacement block
// ----------------------------------------------------------------------------
`default_nettype none

package dlb_pkg;

	localparam int SETS               = 2048;
	localparam int WAYS               = 16;
	localparam int LEADERS_PER_POLICY = 32;

	localparam int SET_W     = $clog2(SETS);
	localparam int WAY_W     = $clog2(WAYS);
	localparam int POS_W     = WAY_W;
	localparam int ROW_CNT_W = SET_W + 1;
	localparam int IN_SET_W  = 11;
	localparam int IN_WAY_W  = 4;

	localparam int LEADER_STRIDE =
		(SETS / (2 * LEADERS_PER_POLICY) == 0) ? 1 : SETS / (2 * LEADERS_PER_POLICY);

	localparam int DEAD_W = 2;
	localparam logic [DEAD_W-1:0] DEAD_MAX = 2'd3;

	localparam int PSEL_W = 10;
	localparam logic [PSEL_W-1:0] PSEL_MID = 10'd512;
	localparam logic [PSEL_W-1:0] PSEL_MAX = 10'd1023;

	localparam int ACC_W  = 32;
	localparam int LFSR_W = 32;
	localparam logic [LFSR_W-1:0] LFSR_TAPS = 32'h8020_0003;
	localparam logic [LFSR_W-1:0] LFSR_SEED = 32'h0000_0001;

	localparam int MASK_K_W = 6;

	// configuration registers
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;
	localparam int DECAY_W    = 5;
	localparam int BIP_W      = 4;
	localparam int THR_W      = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_DECAY  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BIP    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 2'd2;
	localparam logic [DECAY_W-1:0] DECAY_RESET  = 5'd13;
	localparam logic [BIP_W-1:0]   BIP_RESET    = 4'd5;
	localparam logic [THR_W-1:0]   THRESH_RESET = 2'd2;

	typedef logic [SET_W-1:0] set_t;
	typedef logic [WAY_W-1:0] way_t;
	typedef logic [POS_W-1:0] pos_t;
	typedef logic [WAYS-1:0][POS_W-1:0] stack_row_t;
	typedef logic [WAYS-1:0][DEAD_W-1:0] dead_row_t;

	typedef enum logic [1:0] {
		KIND_FOLLOWER,
		KIND_LIP,
		KIND_BIP
	} leader_kind_t;

	typedef struct packed {
		logic         fire;
		logic         hit;
		logic         dead;
		leader_kind_t kind;
	} pol_req_t;

	typedef struct packed {
		logic at_lru;
		logic used_bip;
	} pol_rsp_t;

	function automatic stack_row_t stack_reset_row();
		stack_row_t r;
		for (int w = 0; w < WAYS; w++) begin
			r[w] = POS_W'(w);
		end
		return r;
	endfunction

	function automatic logic [ACC_W-1:0] lsb_mask32(logic [MASK_K_W-1:0] k);
		logic [ACC_W-1:0] m;
		for (int i = 0; i < ACC_W; i++) begin
			m[i] = (MASK_K_W'(i) < k);
		end
		return m;
	endfunction

	function automatic logic [LFSR_W-1:0] lfsr_step(logic [LFSR_W-1:0] l);
		logic [LFSR_W-1:0] n;
		n = l >> 1;
		if (l[0]) begin
			n = n ^ LFSR_TAPS;
		end
		return n;
	endfunction

	function automatic leader_kind_t leader_kind(set_t s);
		leader_kind_t k;
		k = KIND_FOLLOWER;
		if ((s % SET_W'(LEADER_STRIDE)) == '0) begin
			if ((s / SET_W'(LEADER_STRIDE)) < SET_W'(LEADERS_PER_POLICY)) begin
				k = KIND_LIP;
			end else if ((s / SET_W'(LEADER_STRIDE)) < SET_W'(2 * LEADERS_PER_POLICY)) begin
				k = KIND_BIP;
			end
		end
		return k;
	endfunction

	function automatic way_t lru_way(stack_row_t r);
		way_t res;
		logic found;
		res   = '0;
		found = 1'b0;
		for (int w = 0; w < WAYS; w++) begin
			if (!found && r[w] == POS_W'(WAYS - 1)) begin
				res   = WAY_W'(w);
				found = 1'b1;
			end
		end
		return res;
	endfunction

	function automatic stack_row_t move_row(stack_row_t r, way_t way, pos_t np);
		stack_row_t o;
		pos_t op;
		pos_t p;
		o  = r;
		op = r[way];
		for (int w = 0; w < WAYS; w++) begin
			p = r[w];
			if (WAY_W'(w) != way) begin
				if (np < op && p >= np && p < op) begin
					o[w] = p + 1'b1;
				end else if (np > op && p > op && p <= np) begin
					o[w] = p - 1'b1;
				end
			end
		end
		o[way] = np;
		return o;
	endfunction

	function automatic dead_row_t decay_row(dead_row_t r);
		dead_row_t o;
		for (int w = 0; w < WAYS; w++) begin
			o[w] = (r[w] != '0) ? r[w] - 1'b1 : '0;
		end
		return o;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/dlb_ram.sv =====
// ----------------------------------------------------------------------------
// dlb_ram
// simple dual port synchronous ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module dlb_ram #(
	parameter  int WIDTH  = 8,
	parameter  int DEPTH  = 16,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/dlb_policy.sv =====
// ----------------------------------------------------------------------------
// dlb_policy
// set dueling selector, bimodal lfsr and insertion position decision
// ----------------------------------------------------------------------------
`default_nettype none

`include "dip_lip_bip_dead_block_replacement_macros.svh"

module dlb_policy (
	input  logic                      clk,
	input  logic                      arst_n,
	input  dlb_pkg::pol_req_t         req,
	input  logic [dlb_pkg::BIP_W-1:0] bip_chance_log2,
	output dlb_pkg::pol_rsp_t         rsp
);

	import dlb_pkg::*;

	logic [PSEL_W-1:0] psel_q;
	logic [LFSR_W-1:0] lfsr_q;
	logic [LFSR_W-1:0] lfsr_nx;
	logic              use_bip;
	logic              bim_lru;
	logic              consult;

	always_comb begin
		case (req.kind)
			KIND_LIP: use_bip = 1'b0;
			KIND_BIP: use_bip = 1'b1;
			default:  use_bip = (psel_q >= PSEL_MID);
		endcase
		lfsr_nx    = lfsr_step(lfsr_q);
		bim_lru    = (lfsr_nx & lsb_mask32(MASK_K_W'(bip_chance_log2))) == '0;
		consult    = !req.hit && !req.dead && use_bip;
		rsp.used_bip = consult;
		rsp.at_lru   = !req.hit && (req.dead || !use_bip || bim_lru);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			psel_q <= PSEL_MID;
			lfsr_q <= LFSR_SEED;
		end else if (req.fire) begin
			if (consult) begin
				lfsr_q <= lfsr_nx;
			end
			if (!req.hit) begin
				if (req.kind == KIND_LIP && psel_q != '0) begin
					psel_q <= psel_q - 1'b1;
				end else if (req.kind == KIND_BIP && psel_q != PSEL_MAX) begin
					psel_q <= psel_q + 1'b1;
				end
			end
		end
	end

	`DLB_ASSERT_NEXT(a_psel_hold, !(req.fire && !req.hit), $stable(psel_q))
	`DLB_ASSERT_NEXT(a_lfsr_hold, !(req.fire && rsp.used_bip), $stable(lfsr_q))
	`DLB_ASSERT_IMP(a_lfsr_live, 1'b1, lfsr_q != '0)

endmodule

`default_nettype wire

// ===== rtl/dip_lip_bip_dead_block_replacement.sv =====
// ----------------------------------------------------------------------------
// dip_lip_bip_dead_block_replacement
// lru stack replacement with set dueling lip/bip insertion and dead blocks
// ----------------------------------------------------------------------------
// usage:
//   request channel: start with set_index, hit, hit_way; taken when start is
//   high and busy is low. one request at a time.
//   result: done pulses for one cycle with chosen_way, insert_position,
//   used_bip and predicted_dead; the receiver cannot stall it.
//   config channel: cfg_valid/cfg_ready with cfg_index and cfg_data, always
//   ready; write only while the block is idle.
//   sequence: done is high once the block is back in idle, and a new request
//   can be taken in that cycle; no request is taken before the last one is done.
//   each request does the row read, evaluate and write back of the stack and
//   dead counter memories.
//   decay: a request that lands on a decay point first sweeps every dead
//   row through the memory, then does its own access.
//   reset: a clearing pass writes the reset rows, busy high.
// ----------------------------------------------------------------------------
`default_nettype none

`include "dip_lip_bip_dead_block_replacement_macros.svh"

module dip_lip_bip_dead_block_replacement (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [dlb_pkg::IN_SET_W-1:0]   set_index,
	input  logic                           hit,
	input  logic [dlb_pkg::IN_WAY_W-1:0]   hit_way,
	output logic                           done,
	output logic [dlb_pkg::WAY_W-1:0]      chosen_way,
	output logic [dlb_pkg::POS_W-1:0]      insert_position,
	output logic                           used_bip,
	output logic                           predicted_dead,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [dlb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dlb_pkg::CFG_DATA_W-1:0] cfg_data
);

	import dlb_pkg::*;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SWEEP,
		S_READ,
		S_EVAL,
		S_WB
	} state_t;

	state_t               state_q;
	logic [ROW_CNT_W-1:0] row_cnt_q;
	logic                 sw_vld_s1;
	set_t                 sw_addr_s1;

	logic [DECAY_W-1:0] decay_log2_q;
	logic [BIP_W-1:0]   bip_log2_q;
	logic [THR_W-1:0]   thresh_q;
	logic [ACC_W-1:0]   access_count_q;
	logic [ACC_W-1:0]   acc_nx;
	logic               decay_now;

	set_t         set_q;
	logic         hit_q;
	way_t         hit_way_q;
	leader_kind_t kind_q;

	way_t              way_s2;
	logic [DEAD_W-1:0] dnew_s2;
	logic              dead_s2;

	logic              done_q;
	way_t              chosen_way_q;
	pos_t              insert_position_q;
	logic              used_bip_q;
	logic              predicted_dead_q;

	set_t       set_in;
	logic       rd_en;
	set_t       rd_addr;
	logic       stack_we;
	logic       dead_we;
	set_t       wr_addr;
	stack_row_t stack_wr;
	dead_row_t  dead_wr;
	stack_row_t stack_rd;
	dead_row_t  dead_rd;

	way_t              ev_way;
	logic [DEAD_W-1:0] ev_dold;
	logic [DEAD_W-1:0] ev_dnew;
	logic              ev_dead;
	pos_t              wb_pos;
	dead_row_t         wb_dead_row;

	pol_req_t pol_req;
	pol_rsp_t pol_rsp;

	assign set_in    = set_index[SET_W-1:0];
	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;

	assign acc_nx    = access_count_q + 1'b1;
	assign decay_now = (acc_nx & lsb_mask32(MASK_K_W'(decay_log2_q))) == '0;

	// evaluate on the row read back
	always_comb begin
		ev_way  = hit_q ? hit_way_q : lru_way(stack_rd);
		ev_dold = dead_rd[ev_way];
		if (hit_q) begin
			ev_dnew = '0;
		end else if (ev_dold == DEAD_MAX) begin
			ev_dnew = DEAD_MAX;
		end else begin
			ev_dnew = ev_dold + 1'b1;
		end
		ev_dead = (ev_dnew >= thresh_q);
	end

	assign pol_req.fire = (state_q == S_WB);
	assign pol_req.hit  = hit_q;
	assign pol_req.dead = dead_s2;
	assign pol_req.kind = kind_q;

	always_comb begin
		wb_pos              = pol_rsp.at_lru ? POS_W'(WAYS - 1) : '0;
		wb_dead_row         = dead_rd;
		wb_dead_row[way_s2] = dnew_s2;
	end

	// memory port control
	always_comb begin
		rd_en    = 1'b0;
		rd_addr  = set_in;
		stack_we = 1'b0;
		dead_we  = 1'b0;
		wr_addr  = set_q;
		stack_wr = move_row(stack_rd, way_s2, wb_pos);
		dead_wr  = wb_dead_row;
		case (state_q)
			S_CLEAR: begin
				stack_we = 1'b1;
				dead_we  = 1'b1;
				wr_addr  = row_cnt_q[SET_W-1:0];
				stack_wr = stack_reset_row();
				dead_wr  = '0;
			end
			S_IDLE: begin
				rd_en = start;
			end
			S_SWEEP: begin
				rd_en   = (row_cnt_q < ROW_CNT_W'(SETS));
				rd_addr = row_cnt_q[SET_W-1:0];
				dead_we = sw_vld_s1;
				wr_addr = sw_addr_s1;
				dead_wr = decay_row(dead_rd);
			end
			S_READ: begin
				rd_en   = 1'b1;
				rd_addr = set_q;
			end
			S_WB: begin
				stack_we = 1'b1;
				dead_we  = 1'b1;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= S_CLEAR;
			row_cnt_q         <= '0;
			sw_vld_s1         <= 1'b0;
			sw_addr_s1        <= '0;
			decay_log2_q      <= DECAY_RESET;
			bip_log2_q        <= BIP_RESET;
			thresh_q          <= THRESH_RESET;
			access_count_q    <= '0;
			set_q             <= '0;
			hit_q             <= 1'b0;
			hit_way_q         <= '0;
			kind_q            <= KIND_FOLLOWER;
			way_s2            <= '0;
			dnew_s2           <= '0;
			dead_s2           <= 1'b0;
			done_q            <= 1'b0;
			chosen_way_q      <= '0;
			insert_position_q <= '0;
			used_bip_q        <= 1'b0;
			predicted_dead_q  <= 1'b0;
		end else begin
			done_q     <= 1'b0;
			sw_vld_s1  <= (state_q == S_SWEEP) && (row_cnt_q < ROW_CNT_W'(SETS));
			sw_addr_s1 <= row_cnt_q[SET_W-1:0];

			if (cfg_valid) begin
				case (cfg_index)
					CFG_DECAY:  decay_log2_q <= cfg_data[DECAY_W-1:0];
					CFG_BIP:    bip_log2_q   <= cfg_data[BIP_W-1:0];
					CFG_THRESH: thresh_q     <= cfg_data[THR_W-1:0];
					default:    ;
				endcase
			end

			case (state_q)
				S_CLEAR: begin
					if (row_cnt_q == ROW_CNT_W'(SETS - 1)) begin
						row_cnt_q <= '0;
						state_q   <= S_IDLE;
					end else begin
						row_cnt_q <= row_cnt_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (start) begin
						set_q          <= set_in;
						hit_q          <= hit;
						hit_way_q      <= hit_way[WAY_W-1:0];
						kind_q         <= leader_kind(set_in);
						access_count_q <= acc_nx;
						if (decay_now) begin
							row_cnt_q <= '0;
							state_q   <= S_SWEEP;
						end else begin
							state_q <= S_EVAL;
						end
					end
				end
				S_SWEEP: begin
					if (row_cnt_q == ROW_CNT_W'(SETS)) begin
						state_q <= S_READ;
					end else begin
						row_cnt_q <= row_cnt_q + 1'b1;
					end
				end
				S_READ: begin
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					way_s2  <= ev_way;
					dnew_s2 <= ev_dnew;
					dead_s2 <= ev_dead;
					state_q <= S_WB;
				end
				S_WB: begin
					done_q            <= 1'b1;
					chosen_way_q      <= way_s2;
					insert_position_q <= wb_pos;
					used_bip_q        <= pol_rsp.used_bip;
					predicted_dead_q  <= dead_s2;
					state_q           <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done            = done_q;
	assign chosen_way      = chosen_way_q;
	assign insert_position = insert_position_q;
	assign used_bip        = used_bip_q;
	assign predicted_dead  = predicted_dead_q;

	dlb_ram #(
		.WIDTH ($bits(stack_row_t)),
		.DEPTH (SETS)
	) u_stack_ram (
		.clk     (clk),
		.wr_en   (stack_we),
		.wr_addr (wr_addr),
		.wr_data (stack_wr),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (stack_rd)
	);

	dlb_ram #(
		.WIDTH ($bits(dead_row_t)),
		.DEPTH (SETS)
	) u_dead_ram (
		.clk     (clk),
		.wr_en   (dead_we),
		.wr_addr (wr_addr),
		.wr_data (dead_wr),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (dead_rd)
	);

	dlb_policy u_policy (
		.clk             (clk),
		.arst_n          (arst_n),
		.req             (pol_req),
		.bip_chance_log2 (bip_log2_q),
		.rsp             (pol_rsp)
	);

	`DLB_ASSERT_IMP(a_done_idle, done, !busy)
	`DLB_ASSERT_NEXT(a_done_pulse, done, !done)
	`DLB_ASSERT_NEXT(a_request_busy, start && !busy, busy)
	`DLB_ASSERT_IMP(a_pos_ends, done, (insert_position == '0) || (insert_position == POS_W'(WAYS - 1)))
	`DLB_ASSERT_IMP(a_hit_mru, done && hit_q, (insert_position == '0) && !used_bip)

endmodule

`default_nettype wire

// ===== sim/dip_lip_bip_dead_block_replacement_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dip_lip_bip_dead_block_replacement_tb
// drives cache access requests into the replacement block and checks each
// result against a cycle-free model of the lru stacks, dead counters, duel
// selector and lfsr; runs a directed set then random phases under several
// register settings and idle patterns
// ----------------------------------------------------------------------------
module dip_lip_bip_dead_block_replacement_tb;
	import dlb_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int SETTLE_CYCLES  = 20;

	typedef struct packed {
		logic [IN_SET_W-1:0] set_index;
		logic                hit;
		logic [IN_WAY_W-1:0] hit_way;
	} access_t;

	typedef struct packed {
		way_t chosen_way;
		pos_t insert_position;
		logic used_bip;
		logic predicted_dead;
	} choice_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  start     = 1'b0;
	logic [IN_SET_W-1:0]   set_index = '0;
	logic                  hit       = 1'b0;
	logic [IN_WAY_W-1:0]   hit_way   = '0;
	logic                  cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  busy;
	logic                  done;
	way_t                  chosen_way;
	pos_t                  insert_position;
	logic                  used_bip;
	logic                  predicted_dead;
	logic                  cfg_ready;

	// model state
	pos_t               stack_pos [SETS][WAYS];
	logic [DEAD_W-1:0]  dead_cnt [SETS][WAYS];
	logic [PSEL_W-1:0]  psel;
	logic [ACC_W-1:0]   access_cnt;
	logic [LFSR_W-1:0]  lfsr;
	logic [DECAY_W-1:0] decay_log2;
	logic [BIP_W-1:0]   bip_log2;
	logic [THR_W-1:0]   dead_thr;

	access_t pending_reqs[$];
	choice_t due_choices[$];
	access_t cur_req      = '0;
	choice_t want;
	bit      presenting   = 1'b0;
	int      idle_pct     = 0;
	int      err_cnt      = 0;
	int      quiet_cycles = 0;
	int      hot_sets[4];

	dip_lip_bip_dead_block_replacement i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.set_index       (set_index),
		.hit             (hit),
		.hit_way         (hit_way),
		.done            (done),
		.chosen_way      (chosen_way),
		.insert_position (insert_position),
		.used_bip        (used_bip),
		.predicted_dead  (predicted_dead),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic void clear_model();
		for (int i = 0; i < SETS; i++) begin
			for (int j = 0; j < WAYS; j++) begin
				stack_pos[i][j] = POS_W'(j);
				dead_cnt[i][j]  = '0;
			end
		end
		psel       = PSEL_MID;
		access_cnt = '0;
		lfsr       = LFSR_SEED;
		decay_log2 = DECAY_RESET;
		bip_log2   = BIP_RESET;
		dead_thr   = THRESH_RESET;
	endfunction

	function automatic leader_kind_t set_role(int unsigned s);
		int unsigned q;
		if (s % LEADER_STRIDE != 0) begin
			return KIND_FOLLOWER;
		end
		q = s / LEADER_STRIDE;
		if (q < LEADERS_PER_POLICY) begin
			return KIND_LIP;
		end
		if (q < 2 * LEADERS_PER_POLICY) begin
			return KIND_BIP;
		end
		return KIND_FOLLOWER;
	endfunction

	function automatic void predict_replacement(access_t a);
		int unsigned       s;
		int unsigned       way;
		int unsigned       op;
		int unsigned       np;
		int unsigned       p;
		leader_kind_t      role;
		logic [63:0]       decay_mask;
		logic [LFSR_W-1:0] bip_mask;
		logic              go_bip;
		choice_t           c;
		s    = a.set_index % SETS;
		role = set_role(s);
		access_cnt = access_cnt + 1'b1;
		decay_mask = (64'd1 << decay_log2) - 64'd1;
		if (({32'd0, access_cnt} & decay_mask) == 64'd0) begin
			for (int i = 0; i < SETS; i++) begin
				for (int j = 0; j < WAYS; j++) begin
					if (dead_cnt[i][j] != '0) begin
						dead_cnt[i][j] = dead_cnt[i][j] - 1'b1;
					end
				end
			end
		end
		if (a.hit) begin
			way = a.hit_way % WAYS;
		end else begin
			way = 0;
			for (int w = WAYS - 1; w >= 0; w--) begin
				if (stack_pos[s][w] == POS_W'(WAYS - 1)) begin
					way = w;
				end
			end
		end
		if (a.hit) begin
			dead_cnt[s][way] = '0;
		end else if (dead_cnt[s][way] != DEAD_MAX) begin
			dead_cnt[s][way] = dead_cnt[s][way] + 1'b1;
		end
		c.predicted_dead = (dead_cnt[s][way] >= dead_thr);
		c.used_bip       = 1'b0;
		np = 0;
		if (!a.hit) begin
			case (role)
				KIND_LIP: go_bip = 1'b0;
				KIND_BIP: go_bip = 1'b1;
				default:  go_bip = (psel >= PSEL_MID);
			endcase
			if (c.predicted_dead || !go_bip) begin
				np = WAYS - 1;
			end else begin
				c.used_bip = 1'b1;
				lfsr     = (lfsr >> 1) ^ (lfsr[0] ? LFSR_TAPS : '0);
				bip_mask = (LFSR_W'(1) << bip_log2) - 1'b1;
				np       = ((lfsr & bip_mask) == '0) ? WAYS - 1 : 0;
			end
			if (role == KIND_LIP && psel != '0) begin
				psel = psel - 1'b1;
			end else if (role == KIND_BIP && psel != PSEL_MAX) begin
				psel = psel + 1'b1;
			end
		end
		// reorder the stack around the moved way
		op = stack_pos[s][way];
		for (int w = 0; w < WAYS; w++) begin
			p = stack_pos[s][w];
			if (w != way) begin
				if (np < op && p >= np && p < op) begin
					stack_pos[s][w] = POS_W'(p + 1);
				end else if (np > op && p > op && p <= np) begin
					stack_pos[s][w] = POS_W'(p - 1);
				end
			end
		end
		stack_pos[s][way] = POS_W'(np);
		c.chosen_way      = WAY_W'(way);
		c.insert_position = POS_W'(np);
		due_choices.push_back(c);
	endfunction

	function automatic access_t req_of(int unsigned s, bit h, int unsigned w);
		access_t a;
		a.set_index = IN_SET_W'(s);
		a.hit       = h;
		a.hit_way   = IN_WAY_W'(w);
		return a;
	endfunction

	// leader-biased mix; the rest is split between a few hot follower sets
	// and fully random accesses
	function automatic access_t make_access(int lip_pct, int bip_pct);
		access_t     a;
		int unsigned r;
		r = $urandom_range(99);
		a.hit_way = IN_WAY_W'($urandom);
		if (r < lip_pct) begin
			a.set_index = IN_SET_W'(LEADER_STRIDE * $urandom_range(LEADERS_PER_POLICY - 1));
			a.hit       = ($urandom_range(15) == 0);
		end else if (r < lip_pct + bip_pct) begin
			a.set_index = IN_SET_W'(LEADER_STRIDE *
				(LEADERS_PER_POLICY + $urandom_range(LEADERS_PER_POLICY - 1)));
			a.hit       = ($urandom_range(15) == 0);
		end else if ($urandom_range(1) == 0) begin
			a.set_index = IN_SET_W'(hot_sets[$urandom_range(3)]);
			a.hit       = ($urandom_range(2) == 0);
		end else begin
			a.set_index = IN_SET_W'($urandom);
			a.hit       = 1'($urandom_range(1));
		end
		return a;
	endfunction

	task automatic wait_drained();
		do @(negedge clk);
		while (pending_reqs.size() != 0 || presenting || due_choices.size() != 0);
	endtask

	task automatic run_phase(int n, int idle, int lip_pct, int bip_pct);
		@(negedge clk);
		idle_pct = idle;
		for (int i = 0; i < n; i++) begin
			pending_reqs.push_back(make_access(lip_pct, bip_pct));
		end
		wait_drained();
	endtask

	task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
		@(posedge clk);
		while (busy) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_DATA_W'(val);
		do @(posedge clk);
		while (!cfg_ready);
		case (idx)
			CFG_DECAY:  decay_log2 = DECAY_W'(val);
			CFG_BIP:    bip_log2   = BIP_W'(val);
			CFG_THRESH: dead_thr   = THR_W'(val);
			default: ;
		endcase
		cfg_valid <= 1'b0;
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			presenting = 1'b0;
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				predict_replacement(cur_req);
				presenting = 1'b0;
			end
			if (!presenting && pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct) begin
				cur_req    = pending_reqs.pop_front();
				presenting = 1'b1;
			end
			start     <= presenting;
			set_index <= cur_req.set_index;
			hit       <= cur_req.hit;
			hit_way   <= cur_req.hit_way;
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (due_choices.size() == 0) begin
				$error("result with no request outstanding: chosen_way %0d", chosen_way);
				err_cnt++;
			end else begin
				want = due_choices.pop_front();
				if (chosen_way !== want.chosen_way) begin
					$error("chosen_way: expected %0d, actual %0d", want.chosen_way, chosen_way);
					err_cnt++;
				end
				if (insert_position !== want.insert_position) begin
					$error("insert_position: expected %0d, actual %0d",
						want.insert_position, insert_position);
					err_cnt++;
				end
				if (used_bip !== want.used_bip) begin
					$error("used_bip: expected %0d, actual %0d", want.used_bip, used_bip);
					err_cnt++;
				end
				if (predicted_dead !== want.predicted_dead) begin
					$error("predicted_dead: expected %0d, actual %0d",
						want.predicted_dead, predicted_dead);
					err_cnt++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	initial begin
		clear_model();
		for (int k = 0; k < 4; k++) begin
			hot_sets[k] = LEADER_STRIDE * $urandom_range(SETS / LEADER_STRIDE - 1)
				+ 1 + $urandom_range(LEADER_STRIDE - 2);
		end
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// lip leader: repeated misses climb the dead counter to saturation
		repeat (4) pending_reqs.push_back(req_of(0, 1'b0, 0));
		pending_reqs.push_back(req_of(0, 1'b1, 15));
		pending_reqs.push_back(req_of(0, 1'b1, 0));
		// bip leader misses bring the selector back to its midpoint
		repeat (4) pending_reqs.push_back(req_of(1024, 1'b0, 5));
		pending_reqs.push_back(req_of(2047, 1'b0, 0));
		pending_reqs.push_back(req_of(2047, 1'b1, 15));
		pending_reqs.push_back(req_of(2047, 1'b1, 8));
		pending_reqs.push_back(req_of(992, 1'b0, 3));
		pending_reqs.push_back(req_of(2047, 1'b0, 0));
		pending_reqs.push_back(req_of(2016, 1'b0, 12));
		pending_reqs.push_back(req_of(32, 1'b0, 0));
		pending_reqs.push_back(req_of(1023, 1'b0, 0));
		pending_reqs.push_back(req_of(1, 1'b0, 15));
		pending_reqs.push_back(req_of(5, 1'b1, 10));
		wait_drained();

		run_phase(150, 0, 15, 15);

		write_cfg(CFG_DECAY, 20);
		write_cfg(CFG_BIP, 1);
		write_cfg(CFG_THRESH, 3);
		run_phase(300, 47, 95, 0);
		run_phase(300, 47, 95, 0);

		write_cfg(CFG_DECAY, 1);
		write_cfg(CFG_BIP, 10);
		write_cfg(CFG_THRESH, 1);
		run_phase(40, 0, 15, 15);

		write_cfg(CFG_DECAY, 4);
		write_cfg(CFG_BIP, 0);
		write_cfg(CFG_THRESH, 0);
		run_phase(150, 36, 15, 15);

		write_cfg(CFG_DECAY, 0);
		write_cfg(CFG_BIP, 15);
		write_cfg(CFG_THRESH, 3);
		run_phase(20, 47, 15, 15);

		write_cfg(CFG_DECAY, 31);
		write_cfg(CFG_BIP, 3);
		write_cfg(CFG_THRESH, 2);
		run_phase(250, 0, 5, 85);

		write_cfg(CFG_DECAY, 13);
		write_cfg(CFG_BIP, 5);
		write_cfg(CFG_THRESH, 2);
		run_phase(60, 36, 15, 15);

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (err_cnt == 0 && due_choices.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
